### rtl/core/cll_pkg.sv
// ----------------------------------------------------------------------------
// cll_pkg: shared definitions for the circular list with cursor
// Sizes, operation and status codes, controller states, datapath commands
// and the status bundle returned by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cll_pkg;

  localparam int CAPACITY = 64;
  localparam int ELEM_W   = 32;
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int FUNC_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_INS_NODE,
    S_INS_LINK,
    S_REM_READ,
    S_REM_UNLINK,
    S_ADVANCE,
    S_REPORT_A,
    S_REPORT_B,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_FETCH,
    CMD_INS_NODE,
    CMD_INS_LINK,
    CMD_REM_READ,
    CMD_REM_UNLINK,
    CMD_ADVANCE,
    CMD_REPORT_A,
    CMD_REPORT_B,
    CMD_LOAD_OUT
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              op_ok;
    logic              was_empty;
    logic              rsp_busy;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/cll_ctrl.sv
// ----------------------------------------------------------------------------
// cll_ctrl: operation sequencer
// Walks each transaction through fetch, update and report steps and issues
// one datapath command per cycle, pausing while a response is unaccepted.
// ----------------------------------------------------------------------------
`default_nettype none

module cll_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  req_valid,
  output logic                 req_ready,
  input  cll_pkg::dp_status_t  stat,
  output cll_pkg::cmd_t        cmd
);
  import cll_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = !rst;
        if (req_valid && !rst) begin
          cmd        = CMD_ACCEPT;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd = CMD_FETCH;
        if (!stat.op_ok) begin
          state_next = S_REPORT_A;
        end else begin
          case (stat.func)
            FUNC_INSERT:  state_next = S_INS_NODE;
            FUNC_REMOVE:  state_next = S_REM_READ;
            FUNC_ADVANCE: state_next = S_ADVANCE;
            default:      state_next = S_REPORT_A;
          endcase
        end
      end
      S_INS_NODE: begin
        cmd        = CMD_INS_NODE;
        state_next = stat.was_empty ? S_REPORT_A : S_INS_LINK;
      end
      S_INS_LINK: begin
        cmd        = CMD_INS_LINK;
        state_next = S_REPORT_A;
      end
      S_REM_READ: begin
        cmd        = CMD_REM_READ;
        state_next = S_REM_UNLINK;
      end
      S_REM_UNLINK: begin
        cmd        = CMD_REM_UNLINK;
        state_next = S_REPORT_A;
      end
      S_ADVANCE: begin
        cmd        = CMD_ADVANCE;
        state_next = S_REPORT_A;
      end
      S_REPORT_A: begin
        cmd        = CMD_REPORT_A;
        state_next = S_REPORT_B;
      end
      S_REPORT_B: begin
        cmd        = CMD_REPORT_B;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.rsp_busy) begin
          cmd        = CMD_LOAD_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/cll_datapath.sv
// ----------------------------------------------------------------------------
// cll_datapath: node store, free-slot stack and result register
// Holds element and link memories, the free-slot stack with its valid bits,
// cursor, counters and the output register of the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cll_datapath (
  input  wire                                clk,
  input  wire                                rst,
  input  cll_pkg::cmd_t                      cmd,
  output cll_pkg::dp_status_t                stat,
  input  wire  [cll_pkg::FUNC_W-1:0]         func,
  input  wire  [cll_pkg::VALUE_W-1:0]        value,
  output logic                               rsp_valid,
  input  wire                                rsp_ready,
  output logic [cll_pkg::STATUS_W-1:0]       status,
  output logic                               is_empty,
  output logic [cll_pkg::VALUE_W-1:0]        cursor_value,
  output logic [cll_pkg::VALUE_W-1:0]        after_cursor_value,
  output logic [cll_pkg::COUNT_W-1:0]        count
);
  import cll_pkg::*;

  logic [ELEM_W-1:0] val_mem  [CAPACITY];
  logic [SLOT_W-1:0] link_mem [CAPACITY];
  logic [SLOT_W-1:0] free_mem [CAPACITY];
  logic [CAPACITY-1:0] free_vld;

  logic [SLOT_W-1:0]   cur;
  logic [CNT_W-1:0]    node_count;
  logic [CNT_W-1:0]    free_top;

  logic [FUNC_W-1:0]   func_q;
  logic [ELEM_W-1:0]   value_q;
  logic [STATUS_W-1:0] status_q;
  logic                op_ok;
  logic                was_empty;
  logic [SLOT_W-1:0]   new_slot;
  logic [SLOT_W-1:0]   old_slot;
  logic [ELEM_W-1:0]   cur_val;

  logic [SLOT_W-1:0]   link_rd;
  logic [ELEM_W-1:0]   val_rd;
  logic [SLOT_W-1:0]   free_rd;
  logic                free_vld_rd;
  logic [SLOT_W-1:0]   free_idx_rd;

  logic [STATUS_W-1:0] acc_status;
  logic                acc_ok;
  logic                pool_full;
  logic [CNT_W-1:0]    free_dec;
  logic [SLOT_W-1:0]   free_sel;
  logic                rsp_busy;

  logic                link_we, link_re;
  logic [SLOT_W-1:0]   link_wa, link_wd, link_ra;
  logic                val_we, val_re;
  logic [SLOT_W-1:0]   val_wa, val_ra;
  logic                free_we;
  logic [SLOT_W-1:0]   free_wa;

  assign pool_full = (free_top == '0) || (node_count >= CNT_W'(CAPACITY));
  assign free_dec  = free_top - CNT_W'(1);
  assign free_sel  = free_vld_rd ? free_rd : free_idx_rd;
  assign rsp_busy  = rsp_valid && !rsp_ready;

  assign stat.func      = func_q;
  assign stat.op_ok     = op_ok;
  assign stat.was_empty = was_empty;
  assign stat.rsp_busy  = rsp_busy;

  // status decided from the list as it stands when the transaction arrives
  always_comb begin
    acc_status = STATUS_DONE;
    acc_ok     = 1'b1;
    case (func) inside
      FUNC_INSERT: begin
        if (pool_full) begin
          acc_status = STATUS_FULL;
          acc_ok     = 1'b0;
        end
      end
      FUNC_REMOVE, FUNC_ADVANCE: begin
        if (node_count == '0) begin
          acc_status = STATUS_EMPTY;
          acc_ok     = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    link_we = 1'b0;
    link_wa = cur;
    link_wd = link_rd;
    link_re = 1'b0;
    link_ra = cur;
    val_we  = 1'b0;
    val_wa  = free_sel;
    val_re  = 1'b0;
    val_ra  = cur;
    free_we = 1'b0;
    free_wa = free_top[SLOT_W-1:0];
    unique case (cmd)
      CMD_FETCH: begin
        link_re = 1'b1;
      end
      CMD_INS_NODE: begin
        link_we = 1'b1;
        link_wa = free_sel;
        link_wd = was_empty ? free_sel : link_rd;
        val_we  = 1'b1;
      end
      CMD_INS_LINK: begin
        link_we = 1'b1;
        link_wd = new_slot;
      end
      CMD_REM_READ: begin
        link_re = 1'b1;
        link_ra = link_rd;
      end
      CMD_REM_UNLINK: begin
        link_we = (old_slot != cur);
        free_we = (free_top < CNT_W'(CAPACITY));
      end
      CMD_REPORT_A: begin
        link_re = 1'b1;
        val_re  = 1'b1;
      end
      CMD_REPORT_B: begin
        val_re = 1'b1;
        val_ra = link_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (link_re) begin
      link_rd <= link_mem[link_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= value_q;
    end
    if (val_re) begin
      val_rd <= val_mem[val_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (free_we) begin
      free_mem[free_wa] <= old_slot;
    end
    if (cmd == CMD_FETCH) begin
      free_rd     <= free_mem[free_dec[SLOT_W-1:0]];
      free_vld_rd <= free_vld[free_dec[SLOT_W-1:0]];
      free_idx_rd <= free_dec[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur        <= '0;
      node_count <= '0;
      free_top   <= CNT_W'(CAPACITY);
      free_vld   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (free_we) begin
        free_vld[free_wa] <= 1'b1;
      end
      unique case (cmd)
        CMD_INS_NODE: begin
          node_count <= node_count + CNT_W'(1);
          free_top   <= free_dec;
          if (was_empty) begin
            cur <= free_sel;
          end
        end
        CMD_REM_UNLINK: begin
          node_count <= (old_slot == cur) ? '0 : node_count - CNT_W'(1);
          if (free_top < CNT_W'(CAPACITY)) begin
            free_top <= free_top + CNT_W'(1);
          end
        end
        CMD_ADVANCE: begin
          cur <= link_rd;
        end
        default: ;
      endcase
      if (cmd == CMD_LOAD_OUT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_ACCEPT: begin
        func_q    <= func;
        value_q   <= ELEM_W'(value);
        status_q  <= acc_status;
        op_ok     <= acc_ok;
        was_empty <= (node_count == '0);
      end
      CMD_INS_NODE: begin
        new_slot <= free_sel;
      end
      CMD_REM_READ: begin
        old_slot <= link_rd;
      end
      CMD_REPORT_B: begin
        cur_val <= val_rd;
      end
      CMD_LOAD_OUT: begin
        status             <= status_q;
        is_empty           <= (node_count == '0);
        cursor_value       <= (node_count == '0) ? '0 : VALUE_W'(cur_val);
        after_cursor_value <= (node_count == '0) ? '0 : VALUE_W'(val_rd);
        count              <= COUNT_W'(node_count);
      end
      default: ;
    endcase
  end

  a_pool_balance: assert property (@(posedge clk) disable iff (rst)
    ((CNT_W+1)'(node_count) + (CNT_W+1)'(free_top)) == (CNT_W+1)'(CAPACITY))
    else $error("live nodes and free slots do not add up to the pool size");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && is_empty) |-> (cursor_value == '0 && after_cursor_value == '0))
    else $error("empty list reported with nonzero elements");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_LOAD_OUT) |-> !rsp_busy)
    else $error("result loaded over an unaccepted transaction");

endmodule

`default_nettype wire

### rtl/core/circular_list_with_cursor.sv
// ----------------------------------------------------------------------------
// circular_list_with_cursor: bounded circular list with a cursor
// Top level joining the operation sequencer and the list datapath.
// ----------------------------------------------------------------------------
// One request transaction at a time is taken: insert after the cursor, remove
// after the cursor or advance the cursor, and each returns one response that
// describes the list afterwards. Between acceptances a transaction passes
// a fetch step, its update steps (advance; node write and, unless the list
// was empty, link write for insert; read and unlink for remove; none when
// refused or a no-op), set by dependent synchronous reads of the link and
// element memories, then a two-read report step and a done step. The
// response sits in an output register, so a new request is taken while the
// previous response waits; that request then holds in its last step for as
// long as the previous response stays unaccepted. Up to 64 elements of 32
// bits are held; the free-slot stack needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_list_with_cursor (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          req_valid,
  output logic                         req_ready,
  input  wire  [cll_pkg::FUNC_W-1:0]   func,
  input  wire  [cll_pkg::VALUE_W-1:0]  value,
  output logic                         rsp_valid,
  input  wire                          rsp_ready,
  output logic [cll_pkg::STATUS_W-1:0] status,
  output logic                         is_empty,
  output logic [cll_pkg::VALUE_W-1:0]  cursor_value,
  output logic [cll_pkg::VALUE_W-1:0]  after_cursor_value,
  output logic [cll_pkg::COUNT_W-1:0]  count
);
  import cll_pkg::*;

  cmd_t       cmd;
  dp_status_t stat;

  cll_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cll_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .func               (func),
    .value              (value),
    .rsp_valid          (rsp_valid),
    .rsp_ready          (rsp_ready),
    .status             (status),
    .is_empty           (is_empty),
    .cursor_value       (cursor_value),
    .after_cursor_value (after_cursor_value),
    .count              (count)
  );

endmodule

`default_nettype wire

### bench/tb_circular_list_with_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_list_with_cursor: regression bench for the circular list
// Drives insert, remove, advance and unused operations through the request
// channel with random gaps and response stalls. The bench keeps its own copy
// of the node store, links, free-slot stack and cursor, predicts the response
// for each accepted transaction and compares every response field.
// ----------------------------------------------------------------------------

module tb_circular_list_with_cursor;
  import cll_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                is_empty;
    logic [VALUE_W-1:0]  cur;
    logic [VALUE_W-1:0]  nxt;
    logic [COUNT_W-1:0]  count;
  } list_view_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  logic [FUNC_W-1:0]   func = FUNC_INSERT;
  logic [VALUE_W-1:0]  value = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic                is_empty;
  logic [VALUE_W-1:0]  cursor_value;
  logic [VALUE_W-1:0]  after_cursor_value;
  logic [COUNT_W-1:0]  count;

  // bench copy of the list
  logic [VALUE_W-1:0] slot_val [CAPACITY];
  logic [SLOT_W-1:0]  slot_link [CAPACITY];
  logic [SLOT_W-1:0]  free_stack [CAPACITY];
  int                 free_top;
  logic [SLOT_W-1:0]  cur_slot;
  int                 live_count;

  list_view_t pending_views[$];
  int         errors = 0;
  int         cycles = 0;
  bit         steady = 1'b0;
  int         hold_cycles = 0;
  int         stall_left = 0;

  circular_list_with_cursor u_top (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req_ready         (req_ready),
    .func              (func),
    .value             (value),
    .rsp_valid         (rsp_valid),
    .rsp_ready         (rsp_ready),
    .status            (status),
    .is_empty          (is_empty),
    .cursor_value      (cursor_value),
    .after_cursor_value(after_cursor_value),
    .count             (count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("circular_list_with_cursor regression: fail");
      $finish;
    end
  end

  function automatic void clear_list();
    for (int i = 0; i < CAPACITY; i++) begin
      slot_val[i] = '0;
      slot_link[i] = '0;
      free_stack[i] = SLOT_W'(i);
    end
    free_top = CAPACITY;
    cur_slot = '0;
    live_count = 0;
  endfunction

  function automatic list_view_t apply_op(input logic [FUNC_W-1:0] op,
                                          input logic [VALUE_W-1:0] v);
    list_view_t r;
    logic [SLOT_W-1:0] s;
    r.status = STATUS_DONE;
    case (op)
      FUNC_INSERT: begin
        if (live_count >= CAPACITY || free_top == 0) begin
          r.status = STATUS_FULL;
        end else begin
          free_top--;
          s = free_stack[free_top];
          slot_val[s] = v;
          if (live_count == 0) begin
            slot_link[s] = s;
            cur_slot = s;
          end else begin
            slot_link[s] = slot_link[cur_slot];
            slot_link[cur_slot] = s;
          end
          live_count++;
        end
      end
      FUNC_REMOVE: begin
        if (live_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          s = slot_link[cur_slot];
          if (s == cur_slot) begin
            live_count = 0;
          end else begin
            slot_link[cur_slot] = slot_link[s];
            live_count--;
          end
          if (free_top < CAPACITY) begin
            free_stack[free_top] = s;
            free_top++;
          end
        end
      end
      FUNC_ADVANCE: begin
        if (live_count == 0) r.status = STATUS_EMPTY;
        else cur_slot = slot_link[cur_slot];
      end
      default: ;
    endcase
    r.is_empty = (live_count == 0);
    r.cur = r.is_empty ? '0 : slot_val[cur_slot];
    r.nxt = r.is_empty ? '0 : slot_val[slot_link[cur_slot]];
    r.count = COUNT_W'(live_count);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 26) return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
    return $urandom;
  endfunction

  function automatic logic [FUNC_W-1:0] pick_op(input int ins_pct, input int rem_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return FUNC_INSERT;
    if (r < ins_pct + rem_pct) return FUNC_REMOVE;
    if (r < 95) return FUNC_ADVANCE;
    return FUNC_UNUSED;
  endfunction

  // valid stays up from the acceptance edge when no gap follows
  task automatic send_op(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    func <= op;
    value <= v;
    do @(posedge clk); while (!req_ready);
    pending_views.push_back(apply_op(op, v));
  endtask

  // response side: random stalls, plus a counted hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        rsp_ready <= 1'b0;
        hold_cycles--;
      end else if (!steady && stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    list_view_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_views.size() == 0) begin
        $error("response transaction with no expectation waiting");
        errors++;
      end else begin
        want = pending_views.pop_front();
        check_field("status", VALUE_W'(want.status), VALUE_W'(status));
        check_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(is_empty));
        check_field("cursor_value", want.cur, cursor_value);
        check_field("after_cursor_value", want.nxt, after_cursor_value);
        check_field("count", VALUE_W'(want.count), VALUE_W'(count));
      end
    end
  end

  task automatic test_empty_list();
    send_op(FUNC_REMOVE, '0);
    send_op(FUNC_ADVANCE, '1);
    send_op(FUNC_UNUSED, 32'h1234_5678);
  endtask

  task automatic test_single_node();
    send_op(FUNC_INSERT, '0);
    send_op(FUNC_ADVANCE, '0);
    send_op(FUNC_UNUSED, '1);
    send_op(FUNC_REMOVE, '0);
    send_op(FUNC_REMOVE, '0);
    send_op(FUNC_INSERT, '1);
    send_op(FUNC_INSERT, 32'hAAAA_AAAA);
    send_op(FUNC_ADVANCE, '0);
    send_op(FUNC_ADVANCE, '0);
  endtask

  task automatic test_value_bits();
    send_op(FUNC_INSERT, 32'h5555_5555);
    send_op(FUNC_INSERT, 32'h8000_0001);
    send_op(FUNC_ADVANCE, '0);
    send_op(FUNC_REMOVE, '0);
    send_op(FUNC_UNUSED, '0);
    send_op(FUNC_REMOVE, '0);
    send_op(FUNC_REMOVE, '0);
    send_op(FUNC_REMOVE, '0);
    send_op(FUNC_ADVANCE, '0);
  endtask

  task automatic test_fill_to_capacity();
    while (live_count < CAPACITY) begin
      if ($urandom_range(0, 9) == 0) send_op(FUNC_ADVANCE, '0);
      else send_op(FUNC_INSERT, pick_value());
    end
    repeat (3) send_op(FUNC_INSERT, pick_value());
    send_op(FUNC_ADVANCE, '0);
    send_op(FUNC_UNUSED, pick_value());
    send_op(FUNC_INSERT, '1);
    while (live_count > 0) begin
      if ($urandom_range(0, 7) == 0) send_op(FUNC_ADVANCE, '0);
      else send_op(FUNC_REMOVE, '0);
    end
    send_op(FUNC_REMOVE, '0);
  endtask

  task automatic test_random_mix(input int items);
    steady = 1'b1;
    for (int i = 0; i < items; i++) begin
      if (i == 50) steady = 1'b0;
      send_op(pick_op(45, 30), pick_value());
    end
  endtask

  task automatic test_output_holdoff();
    steady = 1'b1;
    hold_cycles = 150;
    for (int i = 0; i < 24; i++) send_op(pick_op(50, 25), pick_value());
    steady = 1'b0;
  endtask

  initial begin
    clear_list();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_single_node();
    test_value_bits();
    test_fill_to_capacity();
    test_random_mix(250);
    test_output_holdoff();
    test_random_mix(60);
    req_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("circular_list_with_cursor regression: pass");
    end else begin
      $display("circular_list_with_cursor regression: fail");
    end
    $finish;
  end

endmodule
